[hdl/plt_pkg.sv]
// Shared types and constants of the peer liveness table.
`timescale 1ns / 1ps
`default_nettype none
package plt_pkg;
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] CMD_REGISTER  = 3'd0;
   localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
   localparam logic [2:0] CMD_ACK       = 3'd2;
   localparam logic [2:0] CMD_SHUTDOWN  = 3'd3;
   localparam logic [2:0] CMD_LIST      = 3'd4;
   localparam logic [2:0] CMD_TICK      = 3'd5;

   localparam logic [2:0] KIND_DONE = 3'd0;
   localparam logic [2:0] KIND_ACK  = 3'd1;
   localparam logic [2:0] KIND_PING = 3'd2;
   localparam logic [2:0] KIND_LIST = 3'd3;
   localparam logic [2:0] KIND_DROP = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DUP      = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] CSR_STALE_AFTER   = 2'd0;
   localparam logic [1:0] CSR_PING_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_MAX_PINGS     = 2'd2;

   localparam logic [7:0] STALE_AFTER_RESET   = 8'd30;
   localparam logic [7:0] PING_INTERVAL_RESET = 8'd10;
   localparam logic [3:0] MAX_PINGS_RESET     = 4'd6;

   typedef enum logic [1:0] {PH_WALK, PH_APPEND, PH_DONE} phase_type;

   typedef struct packed {
      logic [7:0] stale_after;
      logic [7:0] ping_interval;
      logic [3:0] max_pings;
   } cfg_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [3:0]  pings;
      logic [31:0] hb_time;
      logic [31:0] ping_time;
      logic        shutdown;
   } entry_type;

   typedef struct packed {
      logic      start;
      logic      go;
      phase_type phase;
   } ctl_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic step_emit;
      logic need_append;
      logic append_emit;
   } ctl_sts_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] ip;
      logic [15:0] port;
      logic [1:0]  status;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

[hdl/peer_liveness_table.sv]
// Top level of the peer liveness table: control registers, sequencer, table, result register.
//
// Usage:
//  - req_ channel: one transaction per command (register, heartbeat, ack, shutdown,
//    list, tick) with the sender address, port and current time in seconds.
//  - rsp_ channel: the results of a command in order; the final one is a done
//    result with rsp_tlast high and the command status.
//  - csr_ port: write stale_after, ping_interval and max_pings while idle.
// Timing: a command walks the table one entry a cycle through a single read port
// on the entry registers, holding while a result waits (see Stall); the next
// command is taken only once its done result has gone into the result register.
// Only one command is in flight; req_tready is high while the sequencer is idle.
// Reset: the table is empty and the control registers take their default values.
// Stall: a result waits in the output register; the walk holds on the next entry
// that has a result to give and resumes when rsp_tready takes the held one.
`timescale 1ns / 1ps
`default_nettype none
module peer_liveness_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // command[2:0], src_ip[34:3], src_port[50:35], now_seconds[82:51], zero pad
   input  wire logic [87:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // message_kind[2:0], dest_ip[34:3], dest_port[50:35], status[52:51], zero pad
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   plt_pkg::cfg_type     cfg_ff;
   plt_pkg::ctl_cmd_type cmd;
   plt_pkg::ctl_sts_type sts;
   plt_pkg::rsp_type     res, rsp_ff;
   logic rsp_valid_ff;
   logic slot_free, emit;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stale_after   <= plt_pkg::STALE_AFTER_RESET;
         cfg_ff.ping_interval <= plt_pkg::PING_INTERVAL_RESET;
         cfg_ff.max_pings     <= plt_pkg::MAX_PINGS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            plt_pkg::CSR_STALE_AFTER:   cfg_ff.stale_after   <= csr_wdata;
            plt_pkg::CSR_PING_INTERVAL: cfg_ff.ping_interval <= csr_wdata;
            plt_pkg::CSR_MAX_PINGS:     cfg_ff.max_pings     <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // The output register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .slot_free (slot_free),
      .sts       (sts),
      .cmd       (cmd),
      .emit      (emit)
   );

   plt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_command (req_tdata[2:0]),
      .req_ip      (req_tdata[34:3]),
      .req_port    (req_tdata[50:35]),
      .req_now     (req_tdata[82:51]),
      .cmd         (cmd),
      .sts         (sts),
      .res         (res)
   );

   // Result register: load on emit, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) rsp_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_ff.status, rsp_ff.port, rsp_ff.ip, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.last;

   // A new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free) else $error("result overwritten");

   // A command is taken only by an idle sequencer, which is then busy
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("second command taken");

   // The closing result is a done result and nothing else carries tlast
   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last == (rsp_ff.kind == plt_pkg::KIND_DONE)))
      else $error("tlast on wrong result");
endmodule
`default_nettype wire

[hdl/plt_datapath.sv]
// Peer table storage, table walk with in-place compaction, and result formation.
`timescale 1ns / 1ps
`default_nettype none
module plt_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire plt_pkg::cfg_type     cfg,
   input  wire logic [2:0]           req_command,
   input  wire logic [31:0]          req_ip,
   input  wire logic [15:0]          req_port,
   input  wire logic [31:0]          req_now,
   input  wire plt_pkg::ctl_cmd_type cmd,
   output plt_pkg::ctl_sts_type      sts,
   output plt_pkg::rsp_type          res
);
   plt_pkg::entry_type tbl_ff [plt_pkg::TABLE_DEPTH];
   logic [2:0]  op_ff;
   logic [31:0] ip_ff, now_ff;
   logic [15:0] port_ff;
   logic [plt_pkg::CNT_W-1:0] rd_ff, wr_ff, count_ff;
   logic kept_ff, dup_ff, full_ff;

   plt_pkg::entry_type e, upd;
   logic match, stale, ping_due, drop, emit;
   logic [2:0] kind;
   logic room;
   logic [31:0] hb_age, ping_age;

   always_comb begin
      e        = tbl_ff[rd_ff[plt_pkg::IDX_W-1:0]];
      match    = (e.ip == ip_ff) && (e.port == port_ff);
      hb_age   = now_ff - e.hb_time;
      ping_age = now_ff - e.ping_time;
      stale    = hb_age > {24'd0, cfg.stale_after};
      ping_due = ping_age >= {24'd0, cfg.ping_interval};
      upd  = e;
      drop = 1'b0;
      emit = 1'b0;
      kind = plt_pkg::KIND_DONE;
      case (op_ff)
         plt_pkg::CMD_REGISTER: begin
            if (match && e.shutdown) begin
               drop = 1'b1;
               emit = 1'b1;
               kind = plt_pkg::KIND_DROP;
            end
         end
         plt_pkg::CMD_HEARTBEAT: begin
            if (match) begin
               upd.hb_time = now_ff;
               emit = 1'b1;
               kind = plt_pkg::KIND_ACK;
            end
         end
         plt_pkg::CMD_ACK: begin
            if (match) begin
               upd.hb_time = now_ff;
               upd.pings   = 4'd0;
            end
         end
         plt_pkg::CMD_SHUTDOWN: begin
            if (match) begin
               upd.shutdown = 1'b1;
               emit = 1'b1;
               kind = plt_pkg::KIND_PING;
            end
         end
         plt_pkg::CMD_LIST: begin
            emit = 1'b1;
            kind = plt_pkg::KIND_LIST;
         end
         plt_pkg::CMD_TICK: begin
            if (stale) begin
               if (e.shutdown || (e.pings > cfg.max_pings)) begin
                  drop = 1'b1;
                  emit = 1'b1;
                  kind = plt_pkg::KIND_DROP;
               end else if (ping_due) begin
                  if (e.pings != 4'hF) upd.pings = e.pings + 4'd1;
                  upd.ping_time = now_ff;
                  emit = 1'b1;
                  kind = plt_pkg::KIND_PING;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign room = count_ff < plt_pkg::CNT_W'(plt_pkg::TABLE_DEPTH);

   always_comb begin
      sts.walk_done   = (rd_ff == count_ff);
      sts.step_emit   = emit;
      sts.need_append = ((op_ff == plt_pkg::CMD_REGISTER) ||
                         (op_ff == plt_pkg::CMD_HEARTBEAT)) && !kept_ff;
      sts.append_emit = (op_ff == plt_pkg::CMD_REGISTER) && room;
      res = '0;
      case (cmd.phase)
         plt_pkg::PH_WALK: begin
            res.kind = kind;
            res.ip   = e.ip;
            res.port = e.port;
         end
         plt_pkg::PH_APPEND: begin
            res.kind = plt_pkg::KIND_ACK;
            res.ip   = ip_ff;
            res.port = port_ff;
         end
         default: begin
            res.kind = plt_pkg::KIND_DONE;
            res.last = 1'b1;
            if (dup_ff)
               res.status = plt_pkg::ST_DUP;
            else if (full_ff)
               res.status = plt_pkg::ST_FULL;
            else if (((op_ff == plt_pkg::CMD_ACK) || (op_ff == plt_pkg::CMD_SHUTDOWN))
                     && !kept_ff)
               res.status = plt_pkg::ST_NOTFOUND;
            else
               res.status = plt_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
         wr_ff    <= '0;
      end else if (cmd.start) begin
         op_ff   <= req_command;
         ip_ff   <= req_ip;
         port_ff <= req_port;
         now_ff  <= req_now;
         rd_ff   <= '0;
         wr_ff   <= '0;
         kept_ff <= 1'b0;
         dup_ff  <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         case (cmd.phase)
            plt_pkg::PH_WALK: begin
               if (sts.walk_done) begin
                  // close the gaps left by dropped entries
                  count_ff <= wr_ff;
               end else if (cmd.go) begin
                  if (!drop) begin
                     tbl_ff[wr_ff[plt_pkg::IDX_W-1:0]] <= upd;
                     wr_ff <= wr_ff + 1'b1;
                  end
                  rd_ff <= rd_ff + 1'b1;
                  if (match && !drop) begin
                     kept_ff <= 1'b1;
                     if (op_ff == plt_pkg::CMD_REGISTER) dup_ff <= 1'b1;
                  end
               end
            end
            plt_pkg::PH_APPEND: begin
               if (cmd.go) begin
                  if (room) begin
                     tbl_ff[count_ff[plt_pkg::IDX_W-1:0]] <=
                        '{ip: ip_ff, port: port_ff, pings: 4'd0, hb_time: now_ff,
                          ping_time: 32'd0, shutdown: 1'b0};
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     full_ff <= 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end
endmodule
`default_nettype wire

[hdl/plt_ctrl.sv]
// Command sequencer: walk, optional append, then the closing done result.
`timescale 1ns / 1ps
`default_nettype none
module plt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 slot_free,
   input  wire plt_pkg::ctl_sts_type sts,
   output plt_pkg::ctl_cmd_type      cmd,
   output logic                      emit
);
   typedef enum logic [1:0] {S_IDLE, S_WALK, S_APPEND, S_DONE} state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '{start: 1'b0, go: 1'b0, phase: plt_pkg::PH_WALK};
      emit      = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // keep the datapath quiet between commands
            cmd.phase = plt_pkg::PH_DONE;
            req_ready = 1'b1;
            cmd.start = req_valid;
            if (req_valid) state_in = S_WALK;
         end
         S_WALK: begin
            if (sts.walk_done) begin
               state_in = S_APPEND;
            end else if (!sts.step_emit || slot_free) begin
               cmd.go = 1'b1;
               emit   = sts.step_emit;
            end
         end
         S_APPEND: begin
            cmd.phase = plt_pkg::PH_APPEND;
            if (!sts.need_append) begin
               state_in = S_DONE;
            end else if (!sts.append_emit || slot_free) begin
               cmd.go   = 1'b1;
               emit     = sts.append_emit;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.phase = plt_pkg::PH_DONE;
            if (slot_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule
`default_nettype wire
